>>> rtl/core/cpcb_pkg.sv
// ----------------------------------------------------------------------------
// cpcb_pkg
// shared constants and types of the cyclic permutation chain builder
// ----------------------------------------------------------------------------
package cpcb_pkg;

    localparam int MAX_LINES  = 4096;
    localparam int LINE_BITS  = $clog2(MAX_LINES);
    localparam int CNT_BITS   = LINE_BITS + 1;
    localparam int ADDR_BITS  = 40;
    localparam int ARENA_BITS = 41;
    localparam int SEED_BITS  = 64;
    localparam int STEP_BITS  = 7;

    localparam logic [SEED_BITS-1:0] SEED_RESET = 64'h9E37_79B9_7F4A_7C15;

    localparam logic [7:0] REG_SEED   = 8'd0;
    localparam logic [7:0] REG_LINES  = 8'd1;
    localparam logic [7:0] REG_STRIDE = 8'd2;
    localparam logic [7:0] REG_ARENA  = 8'd3;

    localparam logic CMD_BUILD = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_BUILT = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;

    typedef struct packed {
        logic                  start;
        logic [SEED_BITS-1:0]  dividend;
        logic [ARENA_BITS-1:0] divisor;
        logic [STEP_BITS-1:0]  steps;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [ARENA_BITS-1:0] rem;
    } div_rsp_t;

endpackage

>>> rtl/core/cyclic_permutation_chain_builder_core.sv
// ----------------------------------------------------------------------------
// cyclic_permutation_chain_builder_core
// builds a single-cycle slot permutation and answers link reads
// ----------------------------------------------------------------------------
// usage
//   input stream: s_tuser holds the command (build or read), s_tdata the
//   position. output stream: m_tdata holds slot and next address, m_tuser
//   the status. registers are to be written over the cfg channel only while
//   idle (the block does not enforce this); cfg_ready is always high.
//   a read makes two table reads on the single read port of the slot
//   memory; an error read goes straight to the result. a build does the
//   strided fill (stride reduced modulo the arena in 16 divider steps,
//   then one slot a cycle), then the n-1 swaps: each draw goes through
//   the shared remainder unit bit by bit (64 steps) and each swap costs
//   four table accesses.
//   one item is in work at a time; s_tready is high only when idle.
//   the result sits in an output register, so the next item is taken
//   while it waits; if the receiver stalls, the next result waits in the
//   sequencer until the register is free.
//   reset clears the built flag, so reads answer not-built until a build.
// ----------------------------------------------------------------------------
module cyclic_permutation_chain_builder_core
    import cpcb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // position[11:0], zero fill
    input  logic [0:0]  s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // slot_address[39:0], next_address[79:40]
    output logic [1:0]  m_tuser,   // status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD_A = 4'd1;
    localparam logic [3:0] S_RD_B = 4'd2;
    localparam logic [3:0] S_RD_C = 4'd3;
    localparam logic [3:0] S_SMOD = 4'd4;
    localparam logic [3:0] S_FILL = 4'd5;
    localparam logic [3:0] S_XS   = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_RI   = 4'd8;
    localparam logic [3:0] S_RJ   = 4'd9;
    localparam logic [3:0] S_W1   = 4'd10;
    localparam logic [3:0] S_W2   = 4'd11;
    localparam logic [3:0] S_DONE = 4'd12;

    function automatic logic [SEED_BITS-1:0] xorshift(input logic [SEED_BITS-1:0] v);
        logic [SEED_BITS-1:0] x;
        x = v ^ (v << 13);
        x = x ^ (x >> 7);
        x = x ^ (x << 17);
        return x;
    endfunction

    logic [3:0]            state_reg, state_next;
    logic [SEED_BITS-1:0]  seed_reg;
    logic [CNT_BITS-1:0]   lines_reg;
    logic [15:0]           stride_reg;
    logic [ARENA_BITS-1:0] arena_reg;
    logic                  built_reg, built_next;
    logic [CNT_BITS-1:0]   bcount_reg, bcount_next;
    logic [CNT_BITS-1:0]   n_reg, n_next;
    logic [SEED_BITS-1:0]  x_reg, x_next;
    logic [ARENA_BITS-1:0] step_reg, step_next;
    logic [ARENA_BITS-1:0] a_reg, a_next;
    logic [CNT_BITS-1:0]   p_reg, p_next;
    logic [LINE_BITS-1:0]  i_reg, i_next;
    logic [LINE_BITS-1:0]  j_reg, j_next;
    logic [ADDR_BITS-1:0]  ti_reg, ti_next;
    logic [LINE_BITS-1:0]  pos_reg, pos_next;
    logic [LINE_BITS-1:0]  nx_reg, nx_next;
    logic [ADDR_BITS-1:0]  slot_reg, slot_next;
    logic [ADDR_BITS-1:0]  link_reg, link_next;
    logic [1:0]            stat_reg, stat_next;
    logic                  out_valid_reg, out_valid_next;
    logic [79:0]           out_data_reg, out_data_next;
    logic [1:0]            out_user_reg, out_user_next;

    logic                  in_xfer;
    logic [LINE_BITS-1:0]  in_pos;
    logic [CNT_BITS-1:0]   pos_inc;
    logic [ARENA_BITS:0]   fill_sum;
    logic [SEED_BITS-1:0]  x_new;
    div_req_t              dreq;
    div_rsp_t              drsp;
    logic                  wr_en;
    logic [LINE_BITS-1:0]  wr_addr;
    logic [ADDR_BITS-1:0]  wr_data;
    logic                  rd_en;
    logic [LINE_BITS-1:0]  rd_addr;
    logic [ADDR_BITS-1:0]  rd_data;

    assign s_tready  = (state_reg == S_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign in_pos    = s_tdata[LINE_BITS-1:0];
    assign pos_inc   = {1'b0, in_pos} + 1'b1;
    assign fill_sum  = {1'b0, a_reg} + {1'b0, step_reg};
    assign x_new     = xorshift(x_reg);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        built_next     = built_reg;
        bcount_next    = bcount_reg;
        n_next         = n_reg;
        x_next         = x_reg;
        step_next      = step_reg;
        a_next         = a_reg;
        p_next         = p_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        ti_next        = ti_reg;
        pos_next       = pos_reg;
        nx_next        = nx_reg;
        slot_next      = slot_reg;
        link_next      = link_reg;
        stat_next      = stat_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        dreq           = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;
        rd_en          = 1'b0;
        rd_addr        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    slot_next = '0;
                    link_next = '0;
                    stat_next = ST_OK;
                    if (s_tuser[0] == CMD_BUILD)
                    begin
                        n_next = (lines_reg > CNT_BITS'(MAX_LINES)) ?
                                 CNT_BITS'(MAX_LINES) : lines_reg;
                        x_next = seed_reg;
                        a_next = '0;
                        p_next = '0;
                        if (arena_reg == '0)
                        begin
                            step_next  = '0;
                            state_next = S_FILL;
                        end
                        else
                        begin
                            dreq.start    = 1'b1;
                            dreq.dividend = {stride_reg, 48'd0};
                            dreq.divisor  = arena_reg;
                            dreq.steps    = STEP_BITS'(16);
                            state_next    = S_SMOD;
                        end
                    end
                    else if (!built_reg)
                    begin
                        stat_next  = ST_NOT_BUILT;
                        state_next = S_DONE;
                    end
                    else if ({1'b0, in_pos} >= bcount_reg)
                    begin
                        stat_next  = ST_RANGE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        pos_next   = in_pos;
                        nx_next    = (pos_inc >= bcount_reg) ? '0 : pos_inc[LINE_BITS-1:0];
                        state_next = S_RD_A;
                    end
                end
            end
            S_RD_A:
            begin
                rd_en      = 1'b1;
                rd_addr    = pos_reg;
                state_next = S_RD_B;
            end
            S_RD_B:
            begin
                slot_next  = rd_data;
                rd_en      = 1'b1;
                rd_addr    = nx_reg;
                state_next = S_RD_C;
            end
            S_RD_C:
            begin
                link_next  = rd_data;
                state_next = S_DONE;
            end
            S_SMOD:
            begin
                if (drsp.done)
                begin
                    step_next  = drsp.rem;
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                if (p_reg == n_reg)
                begin
                    if (n_reg <= CNT_BITS'(1))
                    begin
                        built_next  = 1'b1;
                        bcount_next = n_reg;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        i_next     = LINE_BITS'(n_reg - 1'b1);
                        state_next = S_XS;
                    end
                end
                else
                begin
                    wr_en   = 1'b1;
                    wr_addr = p_reg[LINE_BITS-1:0];
                    wr_data = a_reg[ADDR_BITS-1:0];
                    // both terms below the arena, so one wrap at most
                    if (fill_sum >= {1'b0, arena_reg})
                        a_next = ARENA_BITS'(fill_sum - {1'b0, arena_reg});
                    else
                        a_next = fill_sum[ARENA_BITS-1:0];
                    p_next = p_reg + 1'b1;
                end
            end
            S_XS:
            begin
                x_next        = x_new;
                dreq.start    = 1'b1;
                dreq.dividend = x_new;
                dreq.divisor  = ARENA_BITS'(i_reg);
                dreq.steps    = STEP_BITS'(SEED_BITS);
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (drsp.done)
                begin
                    j_next     = drsp.rem[LINE_BITS-1:0];
                    state_next = S_RI;
                end
            end
            S_RI:
            begin
                rd_en      = 1'b1;
                rd_addr    = i_reg;
                state_next = S_RJ;
            end
            S_RJ:
            begin
                ti_next    = rd_data;
                rd_en      = 1'b1;
                rd_addr    = j_reg;
                state_next = S_W1;
            end
            S_W1:
            begin
                wr_en      = 1'b1;
                wr_addr    = i_reg;
                wr_data    = rd_data;
                state_next = S_W2;
            end
            S_W2:
            begin
                wr_en   = 1'b1;
                wr_addr = j_reg;
                wr_data = ti_reg;
                if (i_reg == LINE_BITS'(1))
                begin
                    built_next  = 1'b1;
                    bcount_next = n_reg;
                    state_next  = S_DONE;
                end
                else
                begin
                    i_next     = i_reg - 1'b1;
                    state_next = S_XS;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {link_reg, slot_reg};
                    out_user_next  = stat_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            built_reg     <= 1'b0;
            bcount_reg    <= '0;
            out_valid_reg <= 1'b0;
            seed_reg      <= SEED_RESET;
            lines_reg     <= CNT_BITS'(1024);
            stride_reg    <= 16'd8;
            arena_reg     <= ARENA_BITS'(134217728);
        end
        else
        begin
            state_reg     <= state_next;
            built_reg     <= built_next;
            bcount_reg    <= bcount_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SEED:   seed_reg   <= cfg_data;
                    REG_LINES:  lines_reg  <= cfg_data[CNT_BITS-1:0];
                    REG_STRIDE: stride_reg <= cfg_data[15:0];
                    REG_ARENA:  arena_reg  <= cfg_data[ARENA_BITS-1:0];
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        x_reg        <= x_next;
        step_reg     <= step_next;
        a_reg        <= a_next;
        p_reg        <= p_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        ti_reg       <= ti_next;
        pos_reg      <= pos_next;
        nx_reg       <= nx_next;
        slot_reg     <= slot_next;
        link_reg     <= link_next;
        stat_reg     <= stat_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    cpcb_divider u_divider
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    cpcb_table u_table
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // table is written only by the fill and the swap
    a_wr_states: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == S_FILL || state_reg == S_W1 || state_reg == S_W2))
        else $error("table write outside build");

    // the draw index stays below the swap position
    a_draw_below: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RI) |-> (j_reg < i_reg))
        else $error("draw not below swap position");

    // a successful link read needs a built table
    a_read_built: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD_A) |-> (built_reg && ({1'b0, pos_reg} < bcount_reg)))
        else $error("link read without valid position");

    // the divider reports only while the sequencer waits for it
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        drsp.done |-> (state_reg == S_DIV || state_reg == S_SMOD))
        else $error("remainder arrived unexpectedly");

endmodule

>>> rtl/core/cpcb_divider.sv
// ----------------------------------------------------------------------------
// cpcb_divider
// shared restoring remainder unit, one dividend bit per cycle from the top
// ----------------------------------------------------------------------------
module cpcb_divider
    import cpcb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [STEP_BITS-1:0]  cnt_reg, cnt_next;
    logic [ARENA_BITS-1:0] rem_reg, rem_next;
    logic [ARENA_BITS-1:0] div_reg, div_next;
    logic [SEED_BITS-1:0]  dvd_reg, dvd_next;
    logic [ARENA_BITS:0]   trial;

    assign trial = {rem_reg, dvd_reg[SEED_BITS-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        dvd_next  = dvd_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.steps;
            rem_next  = '0;
            div_next  = req.divisor;
            dvd_next  = req.dividend;
        end
        else if (busy_reg)
        begin
            // partial remainder stays below the divisor, so one compare suffices
            if (trial >= {1'b0, div_reg})
                rem_next = ARENA_BITS'(trial - {1'b0, div_reg});
            else
                rem_next = trial[ARENA_BITS-1:0];
            dvd_next = {dvd_reg[SEED_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        dvd_reg <= dvd_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

>>> rtl/core/cpcb_table.sv
// ----------------------------------------------------------------------------
// cpcb_table
// slot table memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module cpcb_table
    import cpcb_pkg::*;
(
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [LINE_BITS-1:0] wr_addr,
    input  logic [ADDR_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [LINE_BITS-1:0] rd_addr,
    output logic [ADDR_BITS-1:0] rd_data
);

    logic [ADDR_BITS-1:0] mem [MAX_LINES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule
